@@ rtl/core/jssfb_pkg.sv @@
`default_nettype none

package jssfb_pkg;

   // frame identifiers and lengths
   localparam logic [10:0] ID_BUTTONS  = 11'h102;
   localparam logic [10:0] ID_DRIVE    = 11'h100;
   localparam logic [3:0]  LEN_BUTTONS = 4'd7;
   localparam logic [3:0]  LEN_DRIVE   = 4'd4;

   // configuration register indexes
   localparam int unsigned CSR_IDX_W = 1;
   localparam int unsigned CSR_DATA_W = 15;
   localparam logic [CSR_IDX_W-1:0] REG_DRIVE_OFFSET  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_REST_DEADBAND = 1'b1;

   localparam logic [7:0]  OFFSET_RESET   = 8'd64;
   localparam logic [14:0] DEADBAND_RESET = 15'd4;
   localparam logic [7:0]  PWM_MAX        = 8'd255;

   localparam int unsigned REQ_DATA_W = 48;
   localparam int unsigned RSP_DATA_W = 72;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BTN,
      ST_MUL1,
      ST_MUL2,
      ST_MIX,
      ST_RND,
      ST_DRV
   } state_type;

   typedef struct packed {
      logic load;
      logic calc_d;
      logic calc_f;
      logic calc_p;
      logic calc_r;
      logic emit_btn;
      logic emit_drv;
   } cmd_type;

   typedef struct packed {
      logic edges_any;
      logic need_drive;
      logic out_free;
   } sts_type;

endpackage

`default_nettype wire

@@ rtl/core/jssfb_ctrl.sv @@
`default_nettype none

module jssfb_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   input  wire logic               req_axes_ok,
   output logic                    ready,
   input  wire jssfb_pkg::sts_type sts,
   output jssfb_pkg::cmd_type      cmd
);
   import jssfb_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      ready    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            ready = 1'b1;
            // a sample without enough axes is consumed and dropped
            if (req_tvalid && req_axes_ok) begin
               cmd.load = 1'b1;
               state_in = ST_BTN;
            end
         end
         ST_BTN: begin
            if (!sts.edges_any) begin
               state_in = sts.need_drive ? ST_MUL1 : ST_IDLE;
            end else if (sts.out_free) begin
               cmd.emit_btn = 1'b1;
               state_in     = sts.need_drive ? ST_MUL1 : ST_IDLE;
            end
         end
         ST_MUL1: begin
            cmd.calc_d = 1'b1;
            state_in   = ST_MUL2;
         end
         ST_MUL2: begin
            cmd.calc_f = 1'b1;
            state_in   = ST_MIX;
         end
         ST_MIX: begin
            cmd.calc_p = 1'b1;
            state_in   = ST_RND;
         end
         ST_RND: begin
            cmd.calc_r = 1'b1;
            state_in   = ST_DRV;
         end
         ST_DRV: begin
            if (sts.out_free) begin
               cmd.emit_drv = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ rtl/core/jssfb_dp.sv @@
`default_nettype none

module jssfb_dp (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_we,
   input  wire logic [jssfb_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [jssfb_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  wire logic [12:0]                         req_buttons,
   input  wire logic signed [15:0]                  req_throttle,
   input  wire logic signed [15:0]                  req_steer,
   input  wire jssfb_pkg::cmd_type                  cmd,
   output jssfb_pkg::sts_type                       sts,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [jssfb_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   output logic                                     rsp_tlast
);
   import jssfb_pkg::*;

   function automatic logic [7:0] round_mag(input logic signed [41:0] p);
      logic [41:0] mag;
      logic [41:0] sum;
      logic [11:0] q;
      mag = p[41] ? 42'(-p) : 42'(p);
      sum = mag + (42'd1 << 29);
      q   = sum[41:30];
      return (q > 12'(PWM_MAX)) ? PWM_MAX : q[7:0];
   endfunction

   // configuration
   logic [7:0]  off_ff;
   logic [14:0] db_ff;

   // item state
   logic [6:0]         prev_slots_ff;
   logic [6:0]         edges_ff;
   logic               at_rest_ff;
   logic               need_drive_ff;
   logic               dir_a_held_ff;
   logic               dir_b_held_ff;
   logic signed [15:0] t_ff;
   logic signed [15:0] s_ff;
   logic signed [24:0] d_ff;
   logic signed [40:0] f_ff;
   logic signed [41:0] pa_ff;
   logic signed [41:0] pb_ff;
   logic               neg_a_ff;
   logic               neg_b_ff;
   logic [7:0]         mag_a_ff;
   logic [7:0]         mag_b_ff;

   // output register
   logic        out_valid_ff;
   logic [10:0] out_ident_ff;
   logic [3:0]  out_len_ff;
   logic [7:0]  out_byte_ff [7];
   logic        out_last_ff;

   logic [6:0]         now_slots;
   logic [16:0]        tmag;
   logic               in_rest;
   logic [7:0]         scale;
   logic signed [24:0] prod_d;
   logic signed [24:0] off_term;
   logic signed [24:0] d_in;
   logic [23:0]        dabs;
   logic signed [40:0] f_in;
   logic signed [41:0] dsh;
   logic signed [41:0] fext;
   logic               dir_a;
   logic               dir_b;

   // slot order: buttons 0, 1, 3, 2, 4, 5, 12
   assign now_slots = {req_buttons[12], req_buttons[5], req_buttons[4], req_buttons[2],
                       req_buttons[3], req_buttons[1], req_buttons[0]};
   assign tmag      = req_throttle[15] ? 17'(-{req_throttle[15], req_throttle})
                                       : 17'({1'b0, req_throttle});
   assign in_rest   = tmag < 17'(db_ff);

   assign scale    = PWM_MAX - off_ff;
   assign prod_d   = $signed({1'b0, scale}) * t_ff;
   assign off_term = $signed({2'b00, off_ff, 15'd0});
   always_comb begin
      if (t_ff > 16'sd0) begin
         d_in = prod_d + off_term;
      end else if (t_ff < 16'sd0) begin
         d_in = prod_d - off_term;
      end else begin
         d_in = prod_d;
      end
   end

   assign dabs = d_ff[24] ? 24'(-d_ff) : d_ff[23:0];
   assign f_in = $signed({1'b0, dabs}) * s_ff;
   assign dsh  = $signed({{2{d_ff[24]}}, d_ff, 15'd0});
   assign fext = $signed({f_ff[40], f_ff});

   // zero magnitude repeats the held direction
   assign dir_a = (mag_a_ff == 8'd0) ? dir_a_held_ff : !neg_a_ff;
   assign dir_b = (mag_b_ff == 8'd0) ? dir_b_held_ff : !neg_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         off_ff        <= OFFSET_RESET;
         db_ff         <= DEADBAND_RESET;
         prev_slots_ff <= '0;
         at_rest_ff    <= 1'b1;
         dir_a_held_ff <= 1'b1;
         dir_b_held_ff <= 1'b1;
         out_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               REG_DRIVE_OFFSET:  off_ff <= csr_wdata[7:0];
               REG_REST_DEADBAND: db_ff  <= csr_wdata[14:0];
               default: ;
            endcase
         end
         if (cmd.load) begin
            prev_slots_ff <= now_slots;
            at_rest_ff    <= in_rest;
         end
         if (cmd.emit_drv) begin
            if (mag_a_ff != 8'd0) begin
               dir_a_held_ff <= !neg_a_ff;
            end
            if (mag_b_ff != 8'd0) begin
               dir_b_held_ff <= !neg_b_ff;
            end
         end
         if (cmd.emit_btn || cmd.emit_drv) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         edges_ff      <= now_slots & ~prev_slots_ff;
         need_drive_ff <= !(in_rest && at_rest_ff);
         t_ff          <= in_rest ? 16'sd0 : req_throttle;
         s_ff          <= req_steer;
      end
      if (cmd.calc_d) begin
         d_ff <= d_in;
      end
      if (cmd.calc_f) begin
         f_ff <= f_in;
      end
      if (cmd.calc_p) begin
         pa_ff <= dsh - fext;
         pb_ff <= dsh + fext;
      end
      if (cmd.calc_r) begin
         neg_a_ff <= pa_ff[41];
         neg_b_ff <= pb_ff[41];
         mag_a_ff <= round_mag(pa_ff);
         mag_b_ff <= round_mag(pb_ff);
      end
      if (cmd.emit_btn) begin
         out_ident_ff <= ID_BUTTONS;
         out_len_ff   <= LEN_BUTTONS;
         for (int i = 0; i < 7; i++) begin
            out_byte_ff[i] <= {7'd0, edges_ff[i]};
         end
         out_last_ff  <= !need_drive_ff;
      end else if (cmd.emit_drv) begin
         out_ident_ff   <= ID_DRIVE;
         out_len_ff     <= LEN_DRIVE;
         out_byte_ff[0] <= {7'd0, dir_a};
         out_byte_ff[1] <= mag_a_ff;
         out_byte_ff[2] <= {7'd0, dir_b};
         out_byte_ff[3] <= mag_b_ff;
         out_byte_ff[4] <= 8'd0;
         out_byte_ff[5] <= 8'd0;
         out_byte_ff[6] <= 8'd0;
         out_last_ff    <= 1'b1;
      end
   end

   assign sts.edges_any  = |edges_ff;
   assign sts.need_drive = need_drive_ff;
   assign sts.out_free   = !out_valid_ff || rsp_tready;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {1'b0, out_byte_ff[6], out_byte_ff[5], out_byte_ff[4], out_byte_ff[3],
                        out_byte_ff[2], out_byte_ff[1], out_byte_ff[0], out_len_ff,
                        out_ident_ff};

endmodule

`default_nettype wire

@@ rtl/core/joystick_skid_steer_frame_builder.sv @@
// A button frame is registered from the ST_BTN state after its sample is accepted, the
// drive frame from ST_DRV after the multiply states ST_MUL1 and ST_MUL2 (one multiply
// each) and the mix and rounding states; either waits while the output register is full.
// The sequencer holds each sample until its last frame is in the output register.
// Reset (synchronous, active high): offset 64, deadband 4, stick at rest, both held
// directions forward, no button pressed, output register empty.
`default_nettype none

module joystick_skid_steer_frame_builder (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // configuration
   input  wire logic                                csr_we,
   input  wire logic [jssfb_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [jssfb_pkg::CSR_DATA_W-1:0]    csr_wdata,
   // samples
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [jssfb_pkg::REQ_DATA_W-1:0]    req_tdata,  // buttons, throttle, steer
   input  wire logic                                req_tuser,  // axes_ok
   // frames
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // frame_ident, length, byte0 .. byte6
   output logic [jssfb_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   output logic                                     rsp_tlast
);
   import jssfb_pkg::*;

   cmd_type cmd;
   sts_type sts;

   jssfb_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_axes_ok (req_tuser),
      .ready       (req_tready),
      .sts         (sts),
      .cmd         (cmd)
   );

   jssfb_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_buttons  (req_tdata[12:0]),
      .req_throttle ($signed(req_tdata[28:13])),
      .req_steer    ($signed(req_tdata[44:29])),
      .cmd          (cmd),
      .sts          (sts),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tlast    (rsp_tlast)
   );

   a_frame_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |->
         (rsp_tdata[10:0] == ID_BUTTONS && rsp_tdata[14:11] == LEN_BUTTONS) ||
         (rsp_tdata[10:0] == ID_DRIVE && rsp_tdata[14:11] == LEN_DRIVE))
      else $error("frame ident and length disagree");

   a_drive_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[10:0] == ID_DRIVE) |->
         rsp_tlast && rsp_tdata[22:16] == 7'd0 && rsp_tdata[38:32] == 7'd0)
      else $error("drive frame not last or direction byte not a flag");

   a_busy_after_load: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser) |=> !req_tready)
      else $error("sample taken while previous one still in work");

endmodule

`default_nettype wire
